FILE: src/slt_pkg.sv
// Shared types, widths and codes for the sorted linked-list table.
package slt_pkg;

  // Default slot store depth
  localparam int LIST_DEPTH_DEF = 64;

  // Fixed field widths
  localparam int KEY_W    = 32;
  localparam int PAY_W    = 32;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 6;
  localparam int COUNT_W  = 7;

  typedef logic [OP_W-1:0]            op_t;
  typedef logic signed [KEY_W-1:0]    key_t;
  typedef logic [PAY_W-1:0]           pay_t;
  typedef logic [STATUS_W-1:0]        status_t;
  typedef logic [SLOT_W-1:0]          slot_t;
  typedef logic [COUNT_W-1:0]         count_t;

  // Operation codes; code 3 is treated as a search
  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_SEARCH = 2'd1;
  localparam op_t OP_CLEAR  = 2'd2;

  // Result status codes
  localparam status_t ST_INSERTED  = 3'd0;
  localparam status_t ST_DUPLICATE = 3'd1;
  localparam status_t ST_FULL      = 3'd2;
  localparam status_t ST_FOUND     = 3'd3;
  localparam status_t ST_NOT_FOUND = 3'd4;
  localparam status_t ST_CLEARED   = 3'd5;

endpackage

FILE: src/slt_if.sv
// Valid/ready channel interfaces for requests and results.
interface slt_in_if;
  import slt_pkg::*;

  logic  valid;
  logic  ready;
  op_t   operation;
  key_t  key;
  pay_t  payload;

  modport source (output valid, output operation, output key, output payload, input ready);
  modport sink   (input valid, input operation, input key, input payload, output ready);
endinterface

interface slt_out_if;
  import slt_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  slot_t   slot;
  pay_t    found_payload;
  count_t  entry_count;

  modport source (output valid, output status, output slot, output found_payload,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input slot, input found_payload,
                  input entry_count, output ready);
endinterface

FILE: src/slt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module slt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/sorted_linked_list_table.sv
// Sorted linked-list table: slot store in RAM, list and free chains through next links.
// Insert walks the list, then fills the free slot and hooks it in; search walks the list
//   (one list slot per cycle through the key and link RAMs); a full store skips the walk.
// Clear sweeps the link RAM one slot a cycle to rebuild the free chain.
// One request is in flight at a time; a finished result may wait in the output register.
// Reset (sync, active low) starts the same link sweep; no request is taken until it ends.
module sorted_linked_list_table #(
  parameter int LIST_DEPTH = slt_pkg::LIST_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  slt_in_if.sink   in_chan,
  slt_out_if.source out_chan
);
  import slt_pkg::*;

  localparam int AW = $clog2(LIST_DEPTH);
  localparam int LW = $clog2(LIST_DEPTH + 1);
  localparam int SW = (AW > SLOT_W) ? AW : SLOT_W;
  localparam int CW = (LW > COUNT_W) ? LW : COUNT_W;
  localparam logic [LW-1:0] NONE = LW'(LIST_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(LIST_DEPTH - 1);

  // Control states
  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_LINK  = 3'd3;
  localparam logic [2:0] S_LINK2 = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] clr_idx_r, clr_idx_nxt;
  logic          clr_pend_r, clr_pend_nxt;
  op_t           op_r, op_nxt;
  key_t          key_r, key_nxt;
  pay_t          pay_r, pay_nxt;
  logic [LW-1:0] head_r, head_nxt;
  logic [LW-1:0] free_r, free_nxt;
  logic [LW-1:0] count_r, count_nxt;
  logic [LW-1:0] cur_r, cur_nxt;
  logic [LW-1:0] prev_r, prev_nxt;
  logic [LW-1:0] after_r, after_nxt;
  logic [LW-1:0] steps_r, steps_nxt;
  status_t       res_status_r, res_status_nxt;
  logic [AW-1:0] res_slot_r, res_slot_nxt;
  pay_t          res_pay_r, res_pay_nxt;

  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r, out_status_nxt;
  slot_t         out_slot_r, out_slot_nxt;
  pay_t          out_pay_r, out_pay_nxt;
  count_t        out_count_r, out_count_nxt;

  // RAM ports
  logic [AW-1:0]          rd_addr;
  logic                   data_we;
  logic [AW-1:0]          data_waddr;
  logic [KEY_W+PAY_W-1:0] data_wdata, data_rd;
  logic                   link_we;
  logic [AW-1:0]          link_waddr;
  logic [LW-1:0]          link_wdata, link_rd;

  logic          in_xfer;
  key_t          rd_key;
  pay_t          rd_pay;
  logic [LW-1:0] rd_link;
  logic          key_less;
  logic [LW-1:0] steps_inc;
  logic [SW-1:0] slot_ext;
  logic [CW-1:0] count_ext;

  slt_ram #(.WIDTH(KEY_W + PAY_W), .DEPTH(LIST_DEPTH)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (data_wdata),
    .raddr (rd_addr),
    .rdata (data_rd)
  );

  slt_ram #(.WIDTH(LW), .DEPTH(LIST_DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (rd_addr),
    .rdata (link_rd)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_xfer       = in_chan.valid && (state_r == S_IDLE);

  // Read data views; out-of-range links count as none
  assign rd_key    = data_rd[KEY_W+PAY_W-1:PAY_W];
  assign rd_pay    = data_rd[PAY_W-1:0];
  assign rd_link   = (link_rd >= NONE) ? NONE : link_rd;
  assign key_less  = (rd_key < key_r);
  assign steps_inc = steps_r + LW'(1);

  // Output field narrowing
  assign slot_ext  = SW'(res_slot_r);
  assign count_ext = CW'(count_r);

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    clr_pend_nxt   = clr_pend_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    pay_nxt        = pay_r;
    head_nxt       = head_r;
    free_nxt       = free_r;
    count_nxt      = count_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    after_nxt      = after_r;
    steps_nxt      = steps_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_pay_nxt    = res_pay_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_pay_nxt    = out_pay_r;
    out_count_nxt  = out_count_r;
    rd_addr        = free_r[AW-1:0];
    data_we        = 1'b0;
    data_waddr     = free_r[AW-1:0];
    data_wdata     = {key_r, pay_r};
    link_we        = 1'b0;
    link_waddr     = clr_idx_r;
    link_wdata     = LW'(clr_idx_r) + LW'(1);

    case (state_r)
      // Rebuild the free chain, one slot a cycle
      S_CLR: begin
        link_we     = 1'b1;
        clr_idx_nxt = clr_idx_r + AW'(1);
        if (clr_idx_r == LAST_IDX) begin
          clr_idx_nxt  = '0;
          clr_pend_nxt = 1'b0;
          state_nxt    = clr_pend_r ? S_OUT : S_IDLE;
        end
      end

      // Take a request and start the walk
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt       = in_chan.operation;
          key_nxt      = in_chan.key;
          pay_nxt      = in_chan.payload;
          res_slot_nxt = '0;
          res_pay_nxt  = '0;
          steps_nxt    = '0;
          prev_nxt     = NONE;
          if (in_chan.operation == OP_CLEAR) begin
            head_nxt       = NONE;
            free_nxt       = '0;
            count_nxt      = '0;
            clr_idx_nxt    = '0;
            clr_pend_nxt   = 1'b1;
            res_status_nxt = ST_CLEARED;
            state_nxt      = S_CLR;
          end else if (in_chan.operation == OP_INSERT && free_r == NONE) begin
            res_status_nxt = ST_FULL;
            state_nxt      = S_OUT;
          end else if (head_r == NONE) begin
            // Empty list: insert goes straight to linking, search misses
            if (in_chan.operation == OP_INSERT) begin
              rd_addr   = free_r[AW-1:0];
              state_nxt = S_LINK;
            end else begin
              res_status_nxt = ST_NOT_FOUND;
              state_nxt      = S_OUT;
            end
          end else begin
            cur_nxt   = head_r;
            rd_addr   = head_r[AW-1:0];
            state_nxt = S_WALK;
          end
        end
      end

      // One list slot per cycle
      S_WALK: begin
        if (key_less) begin
          prev_nxt  = cur_r;
          after_nxt = rd_link;
          steps_nxt = steps_inc;
          if (rd_link == NONE || steps_inc >= NONE) begin
            cur_nxt = NONE;
            if (op_r == OP_INSERT) begin
              rd_addr   = free_r[AW-1:0];
              state_nxt = S_LINK;
            end else begin
              res_status_nxt = ST_NOT_FOUND;
              state_nxt      = S_OUT;
            end
          end else begin
            cur_nxt = rd_link;
            rd_addr = rd_link[AW-1:0];
          end
        end else if (rd_key == key_r) begin
          res_slot_nxt = cur_r[AW-1:0];
          if (op_r == OP_INSERT) begin
            res_status_nxt = ST_DUPLICATE;
          end else begin
            res_status_nxt = ST_FOUND;
            res_pay_nxt    = rd_pay;
          end
          state_nxt = S_OUT;
        end else if (op_r == OP_INSERT) begin
          rd_addr   = free_r[AW-1:0];
          state_nxt = S_LINK;
        end else begin
          res_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_OUT;
        end
      end

      // Fill the free slot and point it at its successor
      S_LINK: begin
        data_we        = 1'b1;
        data_waddr     = free_r[AW-1:0];
        link_we        = 1'b1;
        link_waddr     = free_r[AW-1:0];
        link_wdata     = (prev_r == NONE) ? head_r : after_r;
        free_nxt       = rd_link;
        res_slot_nxt   = free_r[AW-1:0];
        res_status_nxt = ST_INSERTED;
        state_nxt      = S_LINK2;
      end

      // Hook the new slot in behind its predecessor
      S_LINK2: begin
        if (prev_r == NONE) begin
          head_nxt = LW'(res_slot_r);
        end else begin
          link_we    = 1'b1;
          link_waddr = prev_r[AW-1:0];
          link_wdata = LW'(res_slot_r);
        end
        count_nxt = count_r + LW'(1);
        state_nxt = S_OUT;
      end

      // Hand the result to the output register once it is free
      S_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = slot_ext[SLOT_W-1:0];
          out_pay_nxt    = res_pay_r;
          out_count_nxt  = count_ext[COUNT_W-1:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_idx_r   <= '0;
      clr_pend_r  <= 1'b0;
      head_r      <= NONE;
      free_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      clr_pend_r  <= clr_pend_nxt;
      head_r      <= head_nxt;
      free_r      <= free_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    pay_r        <= pay_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    after_r      <= after_nxt;
    steps_r      <= steps_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_pay_r    <= res_pay_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_pay_r    <= out_pay_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.slot          = out_slot_r;
  assign out_chan.found_payload = out_pay_r;
  assign out_chan.entry_count   = out_count_r;

endmodule

FILE: src/slt_checker.sv
// Port-level checks for the sorted linked-list table, bound to the top level.
module slt_checker #(
  parameter int LIST_DEPTH = slt_pkg::LIST_DEPTH_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input slt_pkg::status_t       out_status,
  input slt_pkg::slot_t         out_slot,
  input slt_pkg::pay_t          out_found_payload,
  input slt_pkg::count_t        out_entry_count
);
  import slt_pkg::*;

  localparam int CW = ($clog2(LIST_DEPTH + 1) > COUNT_W) ? $clog2(LIST_DEPTH + 1) : COUNT_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(LIST_DEPTH);

  // A pending result holds until taken
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_entry_count))
    else $error("result dropped or changed while stalled");

  // A full store reports the whole depth as entries
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_entry_count == FULL_CNT[COUNT_W-1:0])
    else $error("full status with wrong entry count");

  // Clear empties the table and reports no slot or data
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_CLEARED |->
      out_entry_count == '0 && out_slot == '0 && out_found_payload == '0)
    else $error("clear result not empty");

  // Only a hit carries data
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_FOUND |-> out_found_payload == '0)
    else $error("payload on a non-hit result");

  // Reset leaves no result pending
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sorted_linked_list_table slt_checker #(.LIST_DEPTH(LIST_DEPTH)) u_slt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_status        (out_chan.status),
  .out_slot          (out_chan.slot),
  .out_found_payload (out_chan.found_payload),
  .out_entry_count   (out_chan.entry_count)
);

FILE: bench/slt_table_scoreboard_pkg.sv
// Scoreboard for the sorted linked-list table: table predictor and in-order result check.
package slt_table_scoreboard_pkg;
  import slt_pkg::*;

  localparam int TBL_DEPTH  = LIST_DEPTH_DEF;
  localparam int NO_SLOT    = TBL_DEPTH;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    status_t status;
    slot_t   slot;
    pay_t    found_payload;
    count_t  entry_count;
  } table_result_t;

  class table_scoreboard;
    key_t          key_mem[TBL_DEPTH];
    pay_t          pay_mem[TBL_DEPTH];
    int            link_mem[TBL_DEPTH];
    bit            occupied[TBL_DEPTH];
    int            head_slot;
    int            free_slot;
    int            entries;
    table_result_t expected_q[$];
    int            mismatches;

    function new();
      mismatches = 0;
      clear_table();
    endfunction

    // Empty list, free chain 0 -> 1 -> ... -> none
    function void clear_table();
      for (int i = 0; i < TBL_DEPTH; i++) begin
        key_mem[i]  = '0;
        pay_mem[i]  = '0;
        link_mem[i] = i + 1;
        occupied[i] = 1'b0;
      end
      head_slot = NO_SLOT;
      free_slot = 0;
      entries   = 0;
    endfunction

    function int next_of(int s);
      if (s >= NO_SLOT) return NO_SLOT;
      return (link_mem[s] >= NO_SLOT) ? NO_SLOT : link_mem[s];
    endfunction

    // Walk the sorted chain to the first key not below k; bounded by the depth
    function int seek(key_t k, output int prev);
      int cur;
      int steps;
      cur   = (head_slot >= NO_SLOT) ? NO_SLOT : head_slot;
      prev  = NO_SLOT;
      steps = 0;
      while (cur < NO_SLOT && steps < TBL_DEPTH && key_mem[cur] < k) begin
        prev = cur;
        cur  = next_of(cur);
        steps++;
      end
      if (steps >= TBL_DEPTH) cur = NO_SLOT;
      return cur;
    endfunction

    // Apply one accepted request to the table copy and queue its result
    function void note_request(op_t op, key_t k, pay_t p);
      table_result_t r;
      int cur;
      int prev;
      int s;
      r = '0;
      if (op == OP_CLEAR) begin
        clear_table();
        r.status = ST_CLEARED;
      end else if (op == OP_INSERT) begin
        // full store wins over the duplicate test
        if (free_slot >= NO_SLOT) begin
          r.status = ST_FULL;
        end else begin
          cur = seek(k, prev);
          if (cur < NO_SLOT && key_mem[cur] == k) begin
            r.status = ST_DUPLICATE;
            r.slot   = slot_t'(cur);
          end else begin
            s           = free_slot;
            free_slot   = next_of(s);
            key_mem[s]  = k;
            pay_mem[s]  = p;
            occupied[s] = 1'b1;
            if (prev >= NO_SLOT) begin
              link_mem[s] = (head_slot >= NO_SLOT) ? NO_SLOT : head_slot;
              head_slot   = s;
            end else begin
              link_mem[s]    = next_of(prev);
              link_mem[prev] = s;
            end
            entries++;
            r.status = ST_INSERTED;
            r.slot   = slot_t'(s);
          end
        end
      end else begin
        // search; the spare code behaves the same
        cur = seek(k, prev);
        if (cur < NO_SLOT && key_mem[cur] == k) begin
          r.status        = ST_FOUND;
          r.slot          = slot_t'(cur);
          r.found_payload = pay_mem[cur];
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      r.entry_count = count_t'(entries);
      expected_q.push_back(r);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("mismatch: %s", msg);
    endfunction

    function string show(table_result_t r);
      return $sformatf("status %0d slot %0d payload %h count %0d",
                       r.status, r.slot, r.found_payload, r.entry_count);
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      if (expected_q.size() == 0) begin
        flag({"result with none outstanding: ", show(got)});
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) flag({"expected ", show(want), ", got ", show(got)});
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Anything still queued at the end never arrived
    function void check_drained();
      while (expected_q.size() > 0) flag({"missing result: ", show(expected_q.pop_front())});
    endfunction

    // Key of a random record on the list; needs entries > 0
    function key_t live_key();
      int s;
      do s = $urandom_range(0, TBL_DEPTH - 1); while (!occupied[s]);
      return key_mem[s];
    endfunction
  endclass

endpackage

FILE: bench/sorted_linked_list_table_test.sv
// Top-level testbench for the sorted linked-list table: stimulus, handshakes and watchdog.
module sorted_linked_list_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import slt_pkg::*;
  import slt_table_scoreboard_pkg::*;

  localparam int   HANG_LIMIT    = 2000;
  localparam int   RANDOM_ITEMS  = 1450;
  localparam int   SETTLE_CYCLES = 2 * TBL_DEPTH + 20;
  localparam op_t  OP_SPARE      = 2'd3;
  localparam key_t KEY_MIN       = 32'sh8000_0000;
  localparam key_t KEY_MAX       = 32'sh7FFF_FFFF;

  typedef enum {PH_FILL, PH_MIXED, PH_LOOKUP, PH_RESTART} phase_kind_t;

  logic clk;
  logic rst_n;

  slt_in_if  in_chan();
  slt_out_if out_chan();

  table_scoreboard sb;
  table_result_t   seen_result;
  bit              quiet;
  bit              hung;
  int              sent;

  sorted_linked_list_table #(.LIST_DEPTH(TBL_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #5 clk = ~clk;

  // Result check on every output transfer
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      seen_result.status        = out_chan.status;
      seen_result.slot          = out_chan.slot;
      seen_result.found_payload = out_chan.found_payload;
      seen_result.entry_count   = out_chan.entry_count;
      sb.check_result(seen_result);
    end
  end

  // Receiver: random stall before each result, none in quiet phases
  initial begin
    int stall;
    out_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      @(negedge clk);
    end
  end

  // One request transfer, preceded by a random gap
  task automatic send_req(op_t op, key_t k, pay_t p);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.operation <= op;
    in_chan.key       <= k;
    in_chan.payload   <= p;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_request(op, k, p);
    sent++;
  endtask

  // Hold the sender off until every outstanding result is back
  task automatic wait_drained();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic watch_for_hang();
    int idle;
    idle = 0;
    while (idle < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) idle = 0;
      else idle++;
    end
    hung = 1'b1;
  endtask

  function automatic key_t extreme_key();
    case ($urandom_range(0, 6))
      0:       return KEY_MIN;
      1:       return KEY_MAX;
      2:       return KEY_MIN + key_t'(1);
      3:       return KEY_MAX - key_t'(1);
      4:       return key_t'(0);
      5:       return key_t'(-1);
      default: return key_t'(50);
    endcase
  endfunction

  // Small pool around zero gives duplicates and dense ordering
  function automatic key_t insert_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15 && sb.entries > 0) return sb.live_key();
    if (r < 45) return key_t'(int'($urandom_range(0, 40)) - 20);
    if (r < 55) return extreme_key();
    return key_t'($urandom);
  endfunction

  // Mostly hits, some near misses just past a live key
  function automatic key_t search_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (sb.entries > 0 && r < 60) return sb.live_key();
    if (sb.entries > 0 && r < 70) return sb.live_key() + key_t'(1);
    if (r < 85) return key_t'(int'($urandom_range(0, 40)) - 20);
    if (r < 92) return extreme_key();
    return key_t'($urandom);
  endfunction

  task automatic random_item(int unsigned insert_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < insert_pct)  send_req(OP_INSERT, insert_key(), $urandom);
    else if (r < 88)     send_req(OP_SEARCH, search_key(), $urandom);
    else if (r < 96)     send_req(OP_SPARE, search_key(), $urandom);
    else                 send_req(OP_CLEAR, key_t'($urandom), $urandom);
  endtask

  task automatic run_stimulus();
    phase_kind_t kind;
    bit          first;
    int          n;

    // Directed: empty table, extremes, head/tail/middle inserts, duplicates, spare code
    send_req(OP_SEARCH, key_t'(0), 32'h0);
    send_req(OP_INSERT, key_t'(0), 32'hFFFF_FFFF);
    send_req(OP_INSERT, KEY_MIN, 32'h0000_0000);
    send_req(OP_INSERT, KEY_MAX, 32'hFFFF_FFFF);
    send_req(OP_INSERT, key_t'(-1), 32'hA5A5_A5A5);
    send_req(OP_INSERT, key_t'(50), 32'h5A5A_5A5A);
    send_req(OP_INSERT, key_t'(50), 32'h1234_5678);
    send_req(OP_INSERT, KEY_MIN, 32'hFFFF_FFFF);
    send_req(OP_SEARCH, KEY_MIN, 32'h0);
    send_req(OP_SEARCH, KEY_MAX, 32'hFFFF_FFFF);
    send_req(OP_SEARCH, key_t'(-1), 32'h0);
    send_req(OP_SEARCH, key_t'(1), 32'h0);
    send_req(OP_SEARCH, key_t'(49), 32'h0);
    send_req(OP_SPARE, key_t'(50), 32'h0);
    send_req(OP_SPARE, key_t'(7), 32'hFFFF_FFFF);
    send_req(OP_SEARCH, KEY_MAX - key_t'(1), 32'h0);
    send_req(OP_CLEAR, KEY_MAX, 32'hFFFF_FFFF);
    send_req(OP_SEARCH, key_t'(50), 32'h0);
    send_req(OP_INSERT, key_t'(50), 32'hDEAD_BEEF);
    send_req(OP_INSERT, KEY_MAX - key_t'(1), 32'h0F0F_0F0F);
    send_req(OP_SEARCH, KEY_MIN + key_t'(1), 32'h0);
    send_req(OP_CLEAR, key_t'(0), 32'h0);

    // Random phases; the first fills the store to overflow
    sent  = 0;
    first = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);
      kind  = first ? PH_FILL : phase_kind_t'($urandom_range(0, 3));
      case (kind)
        PH_FILL: begin
          while (sb.entries < TBL_DEPTH) begin
            if ($urandom_range(0, 4) == 0) send_req(OP_SEARCH, search_key(), $urandom);
            else send_req(OP_INSERT, insert_key(), $urandom);
          end
          repeat ($urandom_range(3, 8)) send_req(OP_INSERT, insert_key(), $urandom);
          send_req(OP_SEARCH, search_key(), $urandom);
        end
        PH_MIXED: begin
          n = $urandom_range(40, 120);
          repeat (n) random_item(45);
        end
        PH_LOOKUP: begin
          n = $urandom_range(30, 90);
          repeat (n) random_item(15);
        end
        default: begin
          send_req(OP_CLEAR, key_t'($urandom), $urandom);
          n = $urandom_range(10, 40);
          repeat (n) random_item(70);
        end
      endcase
      if (first || $urandom_range(0, 2) == 0) wait_drained();
      first = 1'b0;
    end

    quiet = 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.check_drained();
  endtask

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.operation = OP_INSERT;
    in_chan.key       = '0;
    in_chan.payload   = '0;
    quiet             = 1'b0;
    hung              = 1'b0;
    sent              = 0;
    sb                = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    fork
      run_stimulus();
      watch_for_hang();
    join_any
    if (!hung && sb.mismatches == 0) begin
      $display("sorted_linked_list_table_test OK");
    end else begin
      $display("sorted_linked_list_table_test NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/slt_pkg.sv
src/slt_if.sv
src/slt_ram.sv
src/sorted_linked_list_table.sv
src/slt_checker.sv
bench/slt_table_scoreboard_pkg.sv
bench/sorted_linked_list_table_test.sv
